>>> sv/hextile_rectangle_decoder_core_macros.svh
// Assertion macros for the hextile rectangle decoder.
// Expects clk and arst_n in the scope of each use.
`ifndef HEXTILE_RECTANGLE_DECODER_CORE_MACROS_SVH
`define HEXTILE_RECTANGLE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, off while in reset.
`define HXRD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while in reset.
`define HXRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/hxrd_pkg.sv
// Shared types and constants for the hextile rectangle decoder.
// No dependencies.
package hxrd_pkg;

	localparam int unsigned QDEPTH = 8;
	localparam int unsigned QAW    = $clog2(QDEPTH);
	localparam int unsigned QCW    = $clog2(QDEPTH + 1);

	// Register indexes on the configuration port
	localparam logic [2:0] REG_RECT_X   = 3'd0;
	localparam logic [2:0] REG_RECT_Y   = 3'd1;
	localparam logic [2:0] REG_RECT_W   = 3'd2;
	localparam logic [2:0] REG_RECT_H   = 3'd3;
	localparam logic [2:0] REG_FB_WIDTH = 3'd4;

	// Subencoding flag bits
	localparam int unsigned FL_RAW      = 0;
	localparam int unsigned FL_BG       = 1;
	localparam int unsigned FL_FG       = 2;
	localparam int unsigned FL_ANY      = 3;
	localparam int unsigned FL_COLOURED = 4;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] pitch;
	} rect_cfg_t;

	// Results of one byte: an optional fill, then an optional done
	typedef struct packed {
		logic        fill;
		logic        done;
		logic [15:0] x;
		logic [15:0] y;
		logic [4:0]  w;
		logic [4:0]  h;
		logic [31:0] colour;
	} res_t;

	typedef struct packed {
		logic        fill;
		logic        done;
		logic [15:0] x;
		logic [15:0] y;
		logic [4:0]  w;
		logic [4:0]  h;
		logic [31:0] colour;
		logic [31:0] addr;
	} q_entry_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic           part;
	} q_stat_t;

	function automatic logic [4:0] min16(input logic [15:0] v);
		min16 = (v < 16'd16) ? v[4:0] : 5'd16;
	endfunction

endpackage

>>> sv/hextile_rectangle_decoder_core.sv
// Hextile rectangle decoder top level: APB registers, input stage, parser, result queue.
// Depends on hxrd_pkg, hxrd_parse, hxrd_outq and the assertion macro header.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-------------------------------------------
//  byte in  | byte_valid / byte_ready        | stream_byte
//  result   | result_valid / result_ready    | kind fill_x fill_y fill_w fill_h colour
//           |                                |   pixel_address last
//  config   | psel penable pwrite / pready   | paddr pwdata prdata
//
// One byte a cycle is accepted while byte_ready is high; a byte passes the input register
// and res_s2 before its result enters the queue. The byte that closes a rectangle may give
// a fill and a done, two results of one queue entry. byte_ready drops when the 8-entry
// result queue, counting requests in the two stages before it, has no room for one more.
// Reset is asynchronous and takes effect at once; there is no clearing pass.
`include "hextile_rectangle_decoder_core_macros.svh"
module hextile_rectangle_decoder_core import hxrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  stream_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        kind,
	output logic [15:0] fill_x,
	output logic [15:0] fill_y,
	output logic [4:0]  fill_w,
	output logic [4:0]  fill_h,
	output logic [31:0] colour,
	output logic [31:0] pixel_address,
	output logic        last
);

	rect_cfg_t  cfg_q, cfg_d;
	logic       cfg_wr, restart;
	logic [2:0] reg_idx;
	logic       valid_s1;
	logic [7:0] byte_s1;
	res_t       res_s2;
	q_stat_t    q_stat;
	logic [QCW:0] load;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		cfg_d   = cfg_q;
		restart = 1'b0;
		if (cfg_wr) begin
			case (reg_idx)
				REG_RECT_X:   cfg_d.x     = pwdata[15:0];
				REG_RECT_Y:   cfg_d.y     = pwdata[15:0];
				REG_RECT_W:   cfg_d.w     = pwdata[15:0];
				REG_RECT_H:   cfg_d.h     = pwdata[15:0];
				REG_FB_WIDTH: cfg_d.pitch = pwdata[15:0];
				default: begin
				end
			endcase
			restart = reg_idx inside {REG_RECT_X, REG_RECT_Y, REG_RECT_W, REG_RECT_H};
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RECT_X:   prdata = {16'd0, cfg_q.x};
			REG_RECT_Y:   prdata = {16'd0, cfg_q.y};
			REG_RECT_W:   prdata = {16'd0, cfg_q.w};
			REG_RECT_H:   prdata = {16'd0, cfg_q.h};
			REG_FB_WIDTH: prdata = {16'd0, cfg_q.pitch};
			default:      prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x     <= 16'd0;
			cfg_q.y     <= 16'd0;
			cfg_q.w     <= 16'd0;
			cfg_q.h     <= 16'd0;
			cfg_q.pitch <= 16'd1;
		end else begin
			cfg_q <= cfg_d;
		end
	end

	// reserve a queue slot for every request still in flight
	assign load       = {1'b0, q_stat.count} + (QCW + 1)'(valid_s1)
		+ (QCW + 1)'(res_s2.fill | res_s2.done) + (QCW + 1)'(1);
	assign byte_ready = (load <= (QCW + 1)'(QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= byte_valid && byte_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= stream_byte;
		end
	end

	hxrd_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cfg_d    (cfg_d),
		.restart  (restart),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.res_s2   (res_s2)
	);

	hxrd_outq u_outq (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_s2        (res_s2),
		.pitch         (cfg_q.pitch),
		.stat          (q_stat),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.kind          (kind),
		.fill_x        (fill_x),
		.fill_y        (fill_y),
		.fill_w        (fill_w),
		.fill_h        (fill_h),
		.colour        (colour),
		.pixel_address (pixel_address),
		.last          (last)
	);

	`HXRD_ASSERT_NOW(a_queue_bound, 1'b1, q_stat.count <= QCW'(QDEPTH), "result queue overrun")
	`HXRD_ASSERT_NOW(a_done_shape, result_valid && kind, last && fill_w == 5'd0 && fill_h == 5'd0 && pixel_address == 32'd0, "done result malformed")
	`HXRD_ASSERT_NOW(a_part_done, q_stat.part, result_valid && kind, "split entry lost its done result")
	`HXRD_ASSERT_NEXT(a_queue_step, 1'b1, (q_stat.count == $past(q_stat.count)) || (q_stat.count == $past(q_stat.count) + QCW'(1)) || (q_stat.count + QCW'(1) == $past(q_stat.count)), "result queue count jumped")

endmodule

>>> sv/hxrd_parse.sv
// Hextile byte parser: tile walk, colour assembly and fill generation.
// Depends on hxrd_pkg.
module hxrd_parse import hxrd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rect_cfg_t  cfg,
	input  rect_cfg_t  cfg_d,
	input  logic       restart,
	input  logic       valid_s1,
	input  logic [7:0] byte_s1,
	output res_t       res_s2
);

	typedef enum logic [7:0] {
		PH_SUBENC    = 8'b0000_0001,
		PH_RAW       = 8'b0000_0010,
		PH_BG        = 8'b0000_0100,
		PH_FG        = 8'b0000_1000,
		PH_COUNT     = 8'b0001_0000,
		PH_SUBCOLOUR = 8'b0010_0000,
		PH_SUBGEOM   = 8'b0100_0000,
		PH_IDLE      = 8'b1000_0000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [4:0]  flags_q, flags_n;
	logic [1:0]  idx_q, idx_n;
	logic [23:0] asm_q, asm_n;
	logic [8:0]  raw_left_q, raw_left_n;
	logic [7:0]  sub_left_q, sub_left_n;
	logic [7:0]  pos_q, pos_n;
	logic [31:0] bg_q, bg_n, fg_q, fg_n;
	logic [15:0] tile_x_q, tile_x_n, tile_y_q, tile_y_n;
	logic [4:0]  tile_w_q, tile_w_n, tile_h_q, tile_h_n;
	logic [15:0] off_x_q, off_x_n, off_y_q, off_y_n;
	logic [4:0]  raw_col_q, raw_col_n, raw_row_q, raw_row_n;

	logic [31:0] word;
	logic        word_full;
	logic [23:0] asm_add;
	logic [8:0]  tile_area;
	logic [4:0]  col_inc;
	logic        go_next;
	res_t        res;

	assign word      = {byte_s1, asm_q};
	assign word_full = (idx_q == 2'd3);
	assign asm_add   = {16'd0, byte_s1} << {idx_q, 3'b000};
	assign tile_area = {4'd0, tile_w_q} * {4'd0, tile_h_q};
	assign col_inc   = raw_col_q + 5'd1;

	always_comb begin
		phase_n    = phase_q;
		flags_n    = flags_q;
		idx_n      = idx_q;
		asm_n      = asm_q;
		raw_left_n = raw_left_q;
		sub_left_n = sub_left_q;
		pos_n      = pos_q;
		bg_n       = bg_q;
		fg_n       = fg_q;
		tile_x_n   = tile_x_q;
		tile_y_n   = tile_y_q;
		tile_w_n   = tile_w_q;
		tile_h_n   = tile_h_q;
		off_x_n    = off_x_q;
		off_y_n    = off_y_q;
		raw_col_n  = raw_col_q;
		raw_row_n  = raw_row_q;
		go_next    = 1'b0;
		res.fill   = 1'b0;
		res.done   = 1'b0;
		res.x      = tile_x_q;
		res.y      = tile_y_q;
		res.w      = tile_w_q;
		res.h      = tile_h_q;
		res.colour = bg_q;

		if (restart) begin
			off_x_n  = 16'd0;
			off_y_n  = 16'd0;
			tile_x_n = cfg_d.x;
			tile_y_n = cfg_d.y;
			tile_w_n = min16(cfg_d.w);
			tile_h_n = min16(cfg_d.h);
			phase_n  = PH_SUBENC;
			idx_n    = 2'd0;
			asm_n    = 24'd0;
		end else if (valid_s1) begin
			case (phase_q)
				PH_SUBENC: begin
					flags_n = byte_s1[4:0];
					idx_n   = 2'd0;
					asm_n   = 24'd0;
					if (byte_s1[FL_RAW]) begin
						raw_left_n = tile_area;
						raw_col_n  = 5'd0;
						raw_row_n  = 5'd0;
						if (tile_area == 9'd0) begin
							go_next = 1'b1;
						end else begin
							phase_n = PH_RAW;
						end
					end else begin
						// no background given: fill with the stored one
						res.fill = !byte_s1[FL_BG];
						if (byte_s1[FL_BG]) begin
							phase_n = PH_BG;
						end else if (byte_s1[FL_FG]) begin
							phase_n = PH_FG;
						end else if (byte_s1[FL_ANY]) begin
							phase_n = PH_COUNT;
						end else begin
							go_next = 1'b1;
						end
					end
				end
				PH_RAW: begin
					if (word_full) begin
						res.fill   = 1'b1;
						res.x      = tile_x_q + {11'd0, raw_col_q};
						res.y      = tile_y_q + {11'd0, raw_row_q};
						res.w      = 5'd1;
						res.h      = 5'd1;
						res.colour = word;
						idx_n      = 2'd0;
						asm_n      = 24'd0;
						if (col_inc >= tile_w_q) begin
							raw_col_n = 5'd0;
							raw_row_n = raw_row_q + 5'd1;
						end else begin
							raw_col_n = col_inc;
						end
						raw_left_n = raw_left_q - 9'd1;
						go_next    = (raw_left_q == 9'd1);
					end else begin
						asm_n = asm_q | asm_add;
						idx_n = idx_q + 2'd1;
					end
				end
				PH_BG: begin
					if (word_full) begin
						bg_n       = word;
						res.fill   = 1'b1;
						res.colour = word;
						idx_n      = 2'd0;
						asm_n      = 24'd0;
						if (flags_q[FL_FG]) begin
							phase_n = PH_FG;
						end else if (flags_q[FL_ANY]) begin
							phase_n = PH_COUNT;
						end else begin
							go_next = 1'b1;
						end
					end else begin
						asm_n = asm_q | asm_add;
						idx_n = idx_q + 2'd1;
					end
				end
				PH_FG: begin
					if (word_full) begin
						fg_n  = word;
						idx_n = 2'd0;
						asm_n = 24'd0;
						if (flags_q[FL_ANY]) begin
							phase_n = PH_COUNT;
						end else begin
							go_next = 1'b1;
						end
					end else begin
						asm_n = asm_q | asm_add;
						idx_n = idx_q + 2'd1;
					end
				end
				PH_COUNT: begin
					sub_left_n = byte_s1;
					if (byte_s1 == 8'd0) begin
						go_next = 1'b1;
					end else begin
						phase_n = flags_q[FL_COLOURED] ? PH_SUBCOLOUR : PH_SUBGEOM;
						idx_n   = 2'd0;
						asm_n   = 24'd0;
					end
				end
				PH_SUBCOLOUR: begin
					if (word_full) begin
						fg_n    = word;
						idx_n   = 2'd0;
						asm_n   = 24'd0;
						phase_n = PH_SUBGEOM;
					end else begin
						asm_n = asm_q | asm_add;
						idx_n = idx_q + 2'd1;
					end
				end
				PH_SUBGEOM: begin
					if (idx_q == 2'd0) begin
						pos_n = byte_s1;
						idx_n = 2'd1;
					end else begin
						res.fill   = 1'b1;
						res.x      = tile_x_q + {12'd0, pos_q[7:4]};
						res.y      = tile_y_q + {12'd0, pos_q[3:0]};
						res.w      = {1'b0, byte_s1[7:4]} + 5'd1;
						res.h      = {1'b0, byte_s1[3:0]} + 5'd1;
						res.colour = fg_q;
						sub_left_n = sub_left_q - 8'd1;
						if (sub_left_q == 8'd1) begin
							go_next = 1'b1;
						end else begin
							phase_n = flags_q[FL_COLOURED] ? PH_SUBCOLOUR : PH_SUBGEOM;
							idx_n   = 2'd0;
							asm_n   = 24'd0;
						end
					end
				end
				PH_IDLE: begin
					// drop bytes until the rectangle is restarted
				end
				default: begin
				end
			endcase

			// advance to the next tile, or finish the rectangle
			if (go_next) begin
				if ({1'b0, off_x_q} + 17'd16 < {1'b0, cfg.w}) begin
					off_x_n  = off_x_q + 16'd16;
					tile_w_n = min16(cfg.w - off_x_n);
				end else if ({1'b0, off_y_q} + 17'd16 < {1'b0, cfg.h}) begin
					off_x_n  = 16'd0;
					tile_w_n = min16(cfg.w);
					off_y_n  = off_y_q + 16'd16;
					tile_h_n = min16(cfg.h - off_y_n);
				end else begin
					res.done = 1'b1;
				end
				if (res.done) begin
					phase_n = PH_IDLE;
				end else begin
					tile_x_n = cfg.x + off_x_n;
					tile_y_n = cfg.y + off_y_n;
					phase_n  = PH_SUBENC;
					idx_n    = 2'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SUBENC;
			flags_q    <= 5'd0;
			idx_q      <= 2'd0;
			asm_q      <= 24'd0;
			raw_left_q <= 9'd0;
			sub_left_q <= 8'd0;
			pos_q      <= 8'd0;
			bg_q       <= 32'd0;
			fg_q       <= 32'd0;
			tile_x_q   <= 16'd0;
			tile_y_q   <= 16'd0;
			tile_w_q   <= 5'd0;
			tile_h_q   <= 5'd0;
			off_x_q    <= 16'd0;
			off_y_q    <= 16'd0;
			raw_col_q  <= 5'd0;
			raw_row_q  <= 5'd0;
			res_s2     <= '0;
		end else begin
			phase_q    <= phase_n;
			flags_q    <= flags_n;
			idx_q      <= idx_n;
			asm_q      <= asm_n;
			raw_left_q <= raw_left_n;
			sub_left_q <= sub_left_n;
			pos_q      <= pos_n;
			bg_q       <= bg_n;
			fg_q       <= fg_n;
			tile_x_q   <= tile_x_n;
			tile_y_q   <= tile_y_n;
			tile_w_q   <= tile_w_n;
			tile_h_q   <= tile_h_n;
			off_x_q    <= off_x_n;
			off_y_q    <= off_y_n;
			raw_col_q  <= raw_col_n;
			raw_row_q  <= raw_row_n;
			res_s2     <= res;
		end
	end

endmodule

>>> sv/hxrd_outq.sv
// Address computation and result queue; splits an entry into fill and done results.
// Depends on hxrd_pkg.
module hxrd_outq import hxrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  res_t        res_s2,
	input  logic [15:0] pitch,
	output q_stat_t     stat,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        kind,
	output logic [15:0] fill_x,
	output logic [15:0] fill_y,
	output logic [4:0]  fill_w,
	output logic [4:0]  fill_h,
	output logic [31:0] colour,
	output logic [31:0] pixel_address,
	output logic        last
);

	q_entry_t       mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QCW-1:0] count_q;
	logic           part_q;

	q_entry_t wr_entry;
	q_entry_t head;
	logic     push, pop, show_done, take;

	always_comb begin
		wr_entry.fill   = res_s2.fill;
		wr_entry.done   = res_s2.done;
		wr_entry.x      = res_s2.x;
		wr_entry.y      = res_s2.y;
		wr_entry.w      = res_s2.w;
		wr_entry.h      = res_s2.h;
		wr_entry.colour = res_s2.colour;
		wr_entry.addr   = {16'd0, res_s2.y} * {16'd0, pitch} + {16'd0, res_s2.x};
	end

	assign push = res_s2.fill | res_s2.done;
	assign head = mem_q[rptr_q];

	// show the done result once the fill of the same entry is gone
	assign show_done     = !head.fill || part_q;
	assign result_valid  = (count_q != '0);
	assign kind          = show_done;
	assign fill_x        = show_done ? 16'd0 : head.x;
	assign fill_y        = show_done ? 16'd0 : head.y;
	assign fill_w        = show_done ? 5'd0 : head.w;
	assign fill_h        = show_done ? 5'd0 : head.h;
	assign colour        = show_done ? 32'd0 : head.colour;
	assign pixel_address = show_done ? 32'd0 : head.addr;
	assign last          = show_done || !head.done;

	assign take = result_valid && result_ready;
	assign pop  = take && last;

	assign stat.count = count_q;
	assign stat.part  = part_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
			part_q  <= 1'b0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + QCW'(push) - QCW'(pop);
			if (take) begin
				part_q <= !last;
			end
		end
	end

endmodule
